### rtl/vector3_alu_core_defines.svh
// assertion macros for the rtl, used by v3a_front
`ifndef VECTOR3_ALU_CORE_DEFINES_SVH
`define VECTOR3_ALU_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define V3A_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define V3A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/v3a_pkg.sv
package v3a_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int SQ_W      = 64;              // sum of three squares
    localparam int RT_W      = 32;              // its square root
    localparam int QB        = FRAC_BITS + 1;   // unit quotient bits
    localparam int ACC_W     = 68;              // exact signed sums
    localparam int SQRT_LAT  = RT_W;
    localparam int DIV_LAT   = QB;
    localparam int SIDE_LAT  = SQRT_LAT + DIV_LAT;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_SCALE  = 3'd2,
        CMD_NEGATE = 3'd3,
        CMD_DOT    = 3'd4,
        CMD_CROSS  = 3'd5,
        CMD_MAG    = 3'd6,
        CMD_UNIT   = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [2:0]           command;
        logic signed [DW-1:0] a_x;
        logic signed [DW-1:0] a_y;
        logic signed [DW-1:0] a_z;
        logic signed [DW-1:0] b_x;
        logic signed [DW-1:0] b_y;
        logic signed [DW-1:0] b_z;
        logic signed [DW-1:0] scale_factor;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0] res_x;
        logic signed [DW-1:0] res_y;
        logic signed [DW-1:0] res_z;
        logic signed [DW-1:0] res_scalar;
        logic                 saturated;
        logic                 zero_length;
    } t_out_item;

    typedef struct packed {
        logic is_add;
        logic is_sub;
        logic is_scale;
        logic is_neg;
        logic is_dot;
        logic is_cross;
        logic is_mag;
        logic is_unit;
    } t_cls;

    typedef struct packed {
        t_cls     cls;
        t_in_item item;
    } t_q_entry;

    typedef struct packed {
        t_cls                  cls;
        t_out_item             res;
        logic [2:0][DW-1:0]    amag;
        logic [2:0]            aneg;
    } t_side;

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 sat;
    } t_clamp;

    function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    function automatic logic signed [ACC_W-1:0] sx(input logic signed [DW-1:0] v);
        return ACC_W'(v);
    endfunction

    // divide by 2^FRAC_BITS, truncating toward zero
    function automatic logic signed [ACC_W-1:0] rescale(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m = m >> FRAC_BITS;
        return v[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_clamp clamp32(input logic signed [ACC_W-1:0] v);
        t_clamp c;
        if (v > sx(32'sh7FFF_FFFF)) begin
            c.val = 32'sh7FFF_FFFF;
            c.sat = 1'b1;
        end else if (v < sx(32'sh8000_0000)) begin
            c.val = 32'sh8000_0000;
            c.sat = 1'b1;
        end else begin
            c.val = DW'(v);
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

### rtl/v3a_front.sv
module v3a_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  v3a_pkg::t_in_item    i_in_item,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output v3a_pkg::t_q_entry    o_q_entry
);

    v3a_pkg::t_q_entry             r_mem [v3a_pkg::Q_DEPTH];
    logic [v3a_pkg::Q_AW-1:0]      r_wr;
    logic [v3a_pkg::Q_AW-1:0]      r_rd;
    logic [v3a_pkg::Q_CW-1:0]      r_cnt;
    logic                          w_push;
    logic                          w_pop;
    v3a_pkg::t_cls                 w_cls;

    always_comb begin
        w_cls = '0;
        unique case (v3a_pkg::t_cmd'(i_in_item.command))
            v3a_pkg::CMD_ADD:    w_cls.is_add   = 1'b1;
            v3a_pkg::CMD_SUB:    w_cls.is_sub   = 1'b1;
            v3a_pkg::CMD_SCALE:  w_cls.is_scale = 1'b1;
            v3a_pkg::CMD_NEGATE: w_cls.is_neg   = 1'b1;
            v3a_pkg::CMD_DOT:    w_cls.is_dot   = 1'b1;
            v3a_pkg::CMD_CROSS:  w_cls.is_cross = 1'b1;
            v3a_pkg::CMD_MAG:    w_cls.is_mag   = 1'b1;
            v3a_pkg::CMD_UNIT:   w_cls.is_unit  = 1'b1;
            default:             w_cls          = '0;
        endcase
    end

    assign o_in_ready = (r_cnt != v3a_pkg::Q_CW'(v3a_pkg::Q_DEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_entry  = r_mem[r_rd];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= '{cls: w_cls, item: i_in_item};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

`include "vector3_alu_core_defines.svh"

    `V3A_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= v3a_pkg::Q_CW'(v3a_pkg::Q_DEPTH), "queue overfilled")
    `V3A_ASSERT_NEXT(a_cnt_grow, w_push && !w_pop, r_cnt == $past(r_cnt) + 1'b1, "queue count lost a beat")
    `V3A_ASSERT_NOW(a_cls_onehot, o_q_valid, $onehot(o_q_entry.cls), "queued beat not classified")

endmodule

### rtl/v3a_isqrt.sv
module v3a_isqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [v3a_pkg::SQ_W-1:0]   i_rad,
    output logic [v3a_pkg::RT_W-1:0]   o_root
);

    logic [v3a_pkg::SQ_W-1:0] r_rem  [v3a_pkg::RT_W];
    logic [v3a_pkg::RT_W-1:0] r_root [v3a_pkg::RT_W];

    // one root bit per stage, msb first
    for (genvar k = 0; k < v3a_pkg::RT_W; k++) begin : g_stage
        localparam int B = v3a_pkg::RT_W - 1 - k;
        logic [v3a_pkg::SQ_W+1:0] w_rem_in;
        logic [v3a_pkg::SQ_W+1:0] w_try;
        logic [v3a_pkg::RT_W-1:0] w_root_in;

        if (k == 0) begin : g_first
            assign w_rem_in  = {2'b00, i_rad};
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = {2'b00, r_rem[k-1]};
            assign w_root_in = r_root[k-1];
        end

        assign w_try = (({{(v3a_pkg::SQ_W+2-v3a_pkg::RT_W){1'b0}}, w_root_in} << 1)
                       + ((v3a_pkg::SQ_W+2)'(1) << B)) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_in >= w_try) begin
                    r_rem[k]  <= v3a_pkg::SQ_W'(w_rem_in - w_try);
                    r_root[k] <= w_root_in | (v3a_pkg::RT_W'(1) << B);
                end else begin
                    r_rem[k]  <= v3a_pkg::SQ_W'(w_rem_in);
                    r_root[k] <= w_root_in;
                end
            end
        end
    end

    assign o_root = r_root[v3a_pkg::RT_W-1];

endmodule

### rtl/v3a_udiv.sv
module v3a_udiv (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [v3a_pkg::DW-1:0]   i_num,
    input  logic [v3a_pkg::RT_W-1:0] i_den,
    output logic [v3a_pkg::QB-1:0]   o_quo,
    output logic [v3a_pkg::RT_W-1:0] o_den
);

    logic [v3a_pkg::RT_W-1:0] r_rem [v3a_pkg::QB];
    logic [v3a_pkg::QB-1:0]   r_quo [v3a_pkg::QB];
    logic [v3a_pkg::RT_W-1:0] r_den [v3a_pkg::QB];

    // numerator is i_num << FRAC_BITS; quotient fits QB bits since den >= num
    for (genvar k = 0; k < v3a_pkg::QB; k++) begin : g_stage
        logic [v3a_pkg::RT_W-1:0] w_rem_in;
        logic [v3a_pkg::QB-1:0]   w_quo_in;
        logic [v3a_pkg::RT_W-1:0] w_den_in;
        logic                     w_bit;
        logic [v3a_pkg::RT_W:0]   w_sh;

        if (k == 0) begin : g_first
            assign w_rem_in = v3a_pkg::RT_W'(i_num >> 1);
            assign w_quo_in = '0;
            assign w_den_in = i_den;
            assign w_bit    = i_num[0];
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_den_in = r_den[k-1];
            assign w_bit    = 1'b0;
        end

        assign w_sh = {w_rem_in, w_bit};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= w_den_in;
                if (w_sh >= {1'b0, w_den_in}) begin
                    r_rem[k] <= v3a_pkg::RT_W'(w_sh - {1'b0, w_den_in});
                    r_quo[k] <= w_quo_in | (v3a_pkg::QB'(1) << (v3a_pkg::QB - 1 - k));
                end else begin
                    r_rem[k] <= v3a_pkg::RT_W'(w_sh);
                    r_quo[k] <= w_quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[v3a_pkg::QB-1];
    assign o_den = r_den[v3a_pkg::QB-1];

endmodule

### rtl/v3a_back.sv
module v3a_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  v3a_pkg::t_q_entry    i_q_entry,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output v3a_pkg::t_out_item   o_out_item
);

    logic w_en;

    // stage 1: operand selection and magnitudes
    logic                        r1_vld;
    v3a_pkg::t_cls               r1_cls;
    v3a_pkg::t_in_item           r1_item;
    logic [v3a_pkg::DW-1:0]      r1_u [6];
    logic [v3a_pkg::DW-1:0]      r1_v [6];
    logic [5:0]                  r1_neg;
    logic signed [v3a_pkg::DW-1:0] w_su [6];
    logic signed [v3a_pkg::DW-1:0] w_sv [6];

    // stage 2: products
    logic                        r2_vld;
    v3a_pkg::t_cls               r2_cls;
    v3a_pkg::t_in_item           r2_item;
    logic [2*v3a_pkg::DW-1:0]    r2_p [6];
    logic [5:0]                  r2_neg;

    // stage 3: exact sums and clamping
    logic                        r3_vld;
    v3a_pkg::t_side              r3_side;
    logic [v3a_pkg::SQ_W-1:0]    r3_sq;
    logic signed [v3a_pkg::ACC_W-1:0] w_t [6];
    v3a_pkg::t_clamp             w_c [4];
    v3a_pkg::t_side              w_side;
    logic [v3a_pkg::SQ_W-1:0]    w_sq;

    // root and divide pipes with the side payload alongside
    logic                        r_svld [v3a_pkg::SIDE_LAT];
    v3a_pkg::t_side              r_side [v3a_pkg::SIDE_LAT];
    logic [v3a_pkg::RT_W-1:0]    w_root;
    logic [v3a_pkg::QB-1:0]      w_quo [3];
    logic [v3a_pkg::RT_W-1:0]    w_den [3];

    logic                        r_out_valid;
    v3a_pkg::t_out_item          r_out;
    v3a_pkg::t_out_item          n_out;

    assign w_en      = !r_out_valid || i_out_ready;
    assign o_q_ready = w_en;

    always_comb begin
        v3a_pkg::t_in_item it;
        it = i_q_entry.item;
        for (int i = 0; i < 6; i++) begin
            w_su[i] = '0;
            w_sv[i] = '0;
        end
        if (i_q_entry.cls.is_cross) begin
            w_su[0] = it.a_y; w_sv[0] = it.b_z;
            w_su[1] = it.a_z; w_sv[1] = it.b_x;
            w_su[2] = it.a_x; w_sv[2] = it.b_y;
            w_su[3] = it.a_z; w_sv[3] = it.b_y;
            w_su[4] = it.a_x; w_sv[4] = it.b_z;
            w_su[5] = it.a_y; w_sv[5] = it.b_x;
        end else begin
            w_su[0] = it.a_x;
            w_su[1] = it.a_y;
            w_su[2] = it.a_z;
            if (i_q_entry.cls.is_scale) begin
                w_sv[0] = it.scale_factor;
                w_sv[1] = it.scale_factor;
                w_sv[2] = it.scale_factor;
            end else if (i_q_entry.cls.is_dot) begin
                w_sv[0] = it.b_x;
                w_sv[1] = it.b_y;
                w_sv[2] = it.b_z;
            end else begin
                w_sv[0] = it.a_x;
                w_sv[1] = it.a_y;
                w_sv[2] = it.a_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cls  <= i_q_entry.cls;
            r1_item <= i_q_entry.item;
            for (int i = 0; i < 6; i++) begin
                r1_u[i]   <= v3a_pkg::mag32(w_su[i]);
                r1_v[i]   <= v3a_pkg::mag32(w_sv[i]);
                r1_neg[i] <= w_su[i][v3a_pkg::DW-1] ^ w_sv[i][v3a_pkg::DW-1];
            end
            r2_cls  <= r1_cls;
            r2_item <= r1_item;
            r2_neg  <= r1_neg;
            for (int i = 0; i < 6; i++) begin
                r2_p[i] <= r1_u[i] * r1_v[i];
            end
            r3_side <= w_side;
            r3_sq   <= w_sq;
        end
    end

    always_comb begin
        logic signed [v3a_pkg::ACC_W-1:0] acc [4];
        v3a_pkg::t_in_item it;
        it = r2_item;
        for (int i = 0; i < 6; i++) begin
            w_t[i] = r2_neg[i] ? -$signed({4'b0, r2_p[i]}) : $signed({4'b0, r2_p[i]});
        end
        for (int i = 0; i < 4; i++) acc[i] = '0;
        if (r2_cls.is_add) begin
            acc[0] = v3a_pkg::sx(it.a_x) + v3a_pkg::sx(it.b_x);
            acc[1] = v3a_pkg::sx(it.a_y) + v3a_pkg::sx(it.b_y);
            acc[2] = v3a_pkg::sx(it.a_z) + v3a_pkg::sx(it.b_z);
        end else if (r2_cls.is_sub) begin
            acc[0] = v3a_pkg::sx(it.a_x) - v3a_pkg::sx(it.b_x);
            acc[1] = v3a_pkg::sx(it.a_y) - v3a_pkg::sx(it.b_y);
            acc[2] = v3a_pkg::sx(it.a_z) - v3a_pkg::sx(it.b_z);
        end else if (r2_cls.is_neg) begin
            acc[0] = -v3a_pkg::sx(it.a_x);
            acc[1] = -v3a_pkg::sx(it.a_y);
            acc[2] = -v3a_pkg::sx(it.a_z);
        end else if (r2_cls.is_scale) begin
            acc[0] = v3a_pkg::rescale(w_t[0]);
            acc[1] = v3a_pkg::rescale(w_t[1]);
            acc[2] = v3a_pkg::rescale(w_t[2]);
        end else if (r2_cls.is_dot) begin
            acc[3] = v3a_pkg::rescale(w_t[0] + w_t[1] + w_t[2]);
        end else if (r2_cls.is_cross) begin
            acc[0] = v3a_pkg::rescale(w_t[0] - w_t[3]);
            acc[1] = v3a_pkg::rescale(w_t[1] - w_t[4]);
            acc[2] = v3a_pkg::rescale(w_t[2] - w_t[5]);
        end
        for (int i = 0; i < 4; i++) w_c[i] = v3a_pkg::clamp32(acc[i]);
        w_sq = r2_p[0] + r2_p[1] + r2_p[2];

        w_side.cls             = r2_cls;
        w_side.res.res_x       = w_c[0].val;
        w_side.res.res_y       = w_c[1].val;
        w_side.res.res_z       = w_c[2].val;
        w_side.res.res_scalar  = w_c[3].val;
        w_side.res.saturated   = w_c[0].sat | w_c[1].sat | w_c[2].sat | w_c[3].sat;
        w_side.res.zero_length = 1'b0;
        w_side.amag[0] = v3a_pkg::mag32(it.a_x);
        w_side.amag[1] = v3a_pkg::mag32(it.a_y);
        w_side.amag[2] = v3a_pkg::mag32(it.a_z);
        w_side.aneg    = {it.a_z[v3a_pkg::DW-1], it.a_y[v3a_pkg::DW-1],
                          it.a_x[v3a_pkg::DW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r3_side;
            for (int i = 1; i < v3a_pkg::SIDE_LAT; i++) r_side[i] <= r_side[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            for (int i = 0; i < v3a_pkg::SIDE_LAT; i++) r_svld[i] <= 1'b0;
        end else if (w_en) begin
            r1_vld    <= i_q_valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r_svld[0] <= r3_vld;
            for (int i = 1; i < v3a_pkg::SIDE_LAT; i++) r_svld[i] <= r_svld[i-1];
        end
    end

    v3a_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r3_sq),
        .o_root (w_root)
    );

    for (genvar l = 0; l < 3; l++) begin : g_lane
        v3a_udiv u_udiv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_side[v3a_pkg::SQRT_LAT-1].amag[l]),
            .i_den (w_root),
            .o_quo (w_quo[l]),
            .o_den (w_den[l])
        );
    end

    always_comb begin
        v3a_pkg::t_side sd;
        logic [v3a_pkg::DW-1:0] q [3];
        sd    = r_side[v3a_pkg::SIDE_LAT-1];
        n_out = sd.res;
        for (int i = 0; i < 3; i++) begin
            q[i] = v3a_pkg::DW'(w_quo[i]);
            q[i] = sd.aneg[i] ? -q[i] : q[i];
        end
        if (sd.cls.is_unit) begin
            n_out = '0;
            if (w_den[0] == '0) begin
                n_out.zero_length = 1'b1;
            end else begin
                n_out.res_x = $signed(q[0]);
                n_out.res_y = $signed(q[1]);
                n_out.res_z = $signed(q[2]);
            end
        end else if (sd.cls.is_mag) begin
            n_out = '0;
            if (w_den[0][v3a_pkg::RT_W-1]) begin
                n_out.res_scalar = 32'sh7FFF_FFFF;
                n_out.saturated  = 1'b1;
            end else begin
                n_out.res_scalar = $signed(v3a_pkg::DW'(w_den[0]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_svld[v3a_pkg::SIDE_LAT-1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/vector3_alu_core.sv
// three-component vector alu in signed q16.16: add, sub, scale, negate, dot, cross,
// magnitude and unit vector, one result beat per input beat, in order. a four-beat
// queue decouples intake from the arithmetic pipe, which takes one beat per clock while
// it advances and passes it through three multiply/sum stages, a 32-stage square root
// that yields one root bit per stage, a 17-stage divider for the unit quotients, and the
// output register. the pipe advances whenever the output register is empty or being
// taken, so with a ready consumer the sustained rate is one beat per cycle.
module vector3_alu_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  v3a_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output v3a_pkg::t_out_item   o_out_item
);

    logic              w_q_valid;
    logic              w_q_ready;
    v3a_pkg::t_q_entry w_q_entry;

    v3a_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (w_q_valid),
        .i_q_ready  (w_q_ready),
        .o_q_entry  (w_q_entry)
    );

    v3a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_entry   (w_q_entry),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### tb/vector3_alu_core_checker.sv
`timescale 1ns / 100ps

module vector3_alu_core_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  v3a_pkg::t_in_item    i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  v3a_pkg::t_out_item   i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);
    import v3a_pkg::*;

    t_out_item expected_q[$];

    assign o_pending = expected_q.size();

    // sign-magnitude helpers on exact 128-bit signed sums
    function automatic logic signed [127:0] wide(input logic signed [31:0] v);
        return 128'(v);
    endfunction

    function automatic logic signed [127:0] div_frac(input logic signed [127:0] v);
        logic [127:0] m;
        m = v < 0 ? 128'(-v) : 128'(v);
        m = m >> FRAC_BITS;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sh8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0] r;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            logic [63:0] t;
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= v) r = t;
        end
        return r;
    endfunction

    function automatic t_out_item alu_result(input t_in_item it);
        t_out_item r;
        logic signed [127:0] a[3], b[3], s, acc;
        logic [127:0] sq, q;
        logic [63:0] m;
        logic sat;
        r = '0;
        sat = 1'b0;
        a[0] = wide(it.a_x); a[1] = wide(it.a_y); a[2] = wide(it.a_z);
        b[0] = wide(it.b_x); b[1] = wide(it.b_y); b[2] = wide(it.b_z);
        s = wide(it.scale_factor);
        case (t_cmd'(it.command))
            CMD_ADD, CMD_SUB, CMD_NEGATE, CMD_SCALE, CMD_CROSS: begin
                logic [31:0] v[3];
                for (int i = 0; i < 3; i++) begin
                    case (t_cmd'(it.command))
                        CMD_ADD:    acc = a[i] + b[i];
                        CMD_SUB:    acc = a[i] - b[i];
                        CMD_NEGATE: acc = -a[i];
                        CMD_SCALE:  acc = div_frac(a[i] * s);
                        default:    acc = div_frac(a[(i+1)%3] * b[(i+2)%3]
                                                   - a[(i+2)%3] * b[(i+1)%3]);
                    endcase
                    v[i] = sat32(acc, sat);
                end
                r.res_x = v[0]; r.res_y = v[1]; r.res_z = v[2];
            end
            CMD_DOT: begin
                acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                r.res_scalar = sat32(div_frac(acc), sat);
            end
            default: begin
                sq = 128'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                m = floor_sqrt(sq);
                if (t_cmd'(it.command) == CMD_MAG) begin
                    r.res_scalar = sat32($signed({64'd0, m}), sat);
                end else if (m == 0) begin
                    r.zero_length = 1'b1;
                end else begin
                    logic [31:0] v[3];
                    for (int i = 0; i < 3; i++) begin
                        q = (128'(a[i] < 0 ? -a[i] : a[i]) << FRAC_BITS) / 128'(m);
                        acc = a[i] < 0 ? -$signed(q) : $signed(q);
                        v[i] = sat32(acc, sat);
                    end
                    r.res_x = v[0]; r.res_y = v[1]; r.res_z = v[2];
                end
            end
        endcase
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            expected_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) expected_q.push_back(alu_result(i_in_item));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e !== i_out_item) begin
                        o_fail_count <= o_fail_count + 1;
                        if (e.res_x !== i_out_item.res_x)
                            $error("res_x exp %h got %h", e.res_x, i_out_item.res_x);
                        if (e.res_y !== i_out_item.res_y)
                            $error("res_y exp %h got %h", e.res_y, i_out_item.res_y);
                        if (e.res_z !== i_out_item.res_z)
                            $error("res_z exp %h got %h", e.res_z, i_out_item.res_z);
                        if (e.res_scalar !== i_out_item.res_scalar)
                            $error("res_scalar exp %h got %h", e.res_scalar,
                                   i_out_item.res_scalar);
                        if (e.saturated !== i_out_item.saturated)
                            $error("saturated exp %b got %b", e.saturated,
                                   i_out_item.saturated);
                        if (e.zero_length !== i_out_item.zero_length)
                            $error("zero_length exp %b got %b", e.zero_length,
                                   i_out_item.zero_length);
                    end
                end
            end
        end
    end

endmodule

### tb/vector3_alu_core_tb.sv
`timescale 1ns / 100ps

module vector3_alu_core_tb;
    import v3a_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_item;
    int         fail_count;
    int         pending;
    int         send_idle_pct;
    int         recv_stall_pct;

    vector3_alu_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    vector3_alu_core_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("vector3_alu_core_tb: errors");
        $finish;
    end

    // receiver stalls at random, rate set by the phase
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] rand_comp(input int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
            2: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
        endcase
    endfunction

    // valid drops only while idling, so back-to-back beats keep it high
    task automatic send_beat(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_vec(input t_cmd op, input logic [31:0] ax, ay, az,
                            input logic [31:0] bx, by, bz, input logic [31:0] sf);
        t_in_item it;
        it = '{op, ax, ay, az, bx, by, bz, sf};
        send_beat(it);
    endtask

    task automatic send_random(input int count);
        t_in_item it;
        int style;
        for (int n = 0; n < count; n++) begin
            style = $urandom_range(3);
            it.command      = 3'($urandom_range(7));
            it.a_x          = rand_comp(style);
            it.a_y          = rand_comp(style);
            it.a_z          = rand_comp(style);
            it.b_x          = rand_comp($urandom_range(3));
            it.b_y          = rand_comp($urandom_range(3));
            it.b_z          = rand_comp($urandom_range(3));
            it.scale_factor = rand_comp($urandom_range(3));
            if ($urandom_range(15) == 0) begin
                it.a_x = '0; it.a_y = '0; it.a_z = '0;
            end
            send_beat(it);
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: each op, range extremes, zero vector, negate of most negative
        send_vec(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'h0);
        send_vec(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5, 32'h1, 32'hFFFF_FFFF,
                 32'h3, 32'h0);
        send_vec(CMD_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000, 32'h0,
                 32'h0, 32'h0, 32'h8000_0000);
        send_vec(CMD_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0002_0000, 32'h0,
                 32'h0, 32'h0, 32'h0000_8000);
        send_vec(CMD_NEGATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
                 32'h0, 32'h0);
        send_vec(CMD_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_vec(CMD_DOT, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0003_0000,
                 32'h0, 32'h0001_0000, 32'h0);
        send_vec(CMD_CROSS, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                 32'h0, 32'h0);
        send_vec(CMD_CROSS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_vec(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
                 32'h0, 32'h0);
        send_vec(CMD_MAG, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                 32'h0);
        send_vec(CMD_MAG, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vec(CMD_UNIT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vec(CMD_UNIT, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vec(CMD_UNIT, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                 32'h0);
        send_vec(CMD_UNIT, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
        send_vec(CMD_UNIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                 32'h0, 32'h0);

        send_random(500);
        send_idle_pct = 58;
        send_random(450);
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        send_random(450);
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        send_random(400);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0) begin
            $display("vector3_alu_core_tb: clean");
        end else begin
            $display("vector3_alu_core_tb: errors");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/v3a_pkg.sv
rtl/v3a_front.sv
rtl/v3a_isqrt.sv
rtl/v3a_udiv.sv
rtl/v3a_back.sv
rtl/vector3_alu_core.sv
tb/vector3_alu_core_checker.sv
tb/vector3_alu_core_tb.sv
